// ===== hw/rtl/gpd_pkg.sv =====
// Types and constants shared by the grace period detector.
`timescale 1ns / 1ps

package gpd_pkg;

  // Event commands
  localparam logic [1:0] CMD_TICK    = 2'd0;
  localparam logic [1:0] CMD_PROCESS = 2'd1;
  localparam logic [1:0] CMD_ONLINE  = 2'd2;
  localparam logic [1:0] CMD_OFFLINE = 2'd3;

  // Configuration register indexes
  localparam logic REG_ONLINE = 1'b0;
  localparam logic REG_NOHZ   = 1'b1;

  // Batch counters come out of reset at minus 300
  localparam logic [31:0] RESET_NUMBER = 32'hFFFF_FED4;

  // Reset values of the configuration masks
  localparam logic [15:0] ONLINE_RESET = 16'h0001;
  localparam logic [15:0] NOHZ_RESET   = 16'h0000;

  // One per-processor entry of the tracking memory
  typedef struct packed {
    logic [31:0] qs_counter;
    logic [31:0] qs_snapshot;
    logic [31:0] seen_batch;
    logic        qs_wanted;
    logic [31:0] wait_batch;
    logic        holds_current;
  } cpu_entry_t;

endpackage

// ===== hw/rtl/grace_period_detector.sv =====
// Grace period detector: per-processor tracking memory and global batch counters.
// Results strobe on valid_o once an accepted event has passed ex_q and then valid_q.
// One event at a time: the block takes no new event between the read and the write back
// of the per-processor memory (busy_o is high while the event executes).
// Reset: counters go to minus 300, masks to their defaults, and per-entry valid bits
// clear at once, so no clearing pass is needed. The receiver cannot stall results.
`timescale 1ns / 1ps

module grace_period_detector #(
  parameter int NUM_CPUS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // event command
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  cmd_i,
  input  logic [3:0]  cpu_i,
  input  logic        has_new_i,
  // result beat
  output logic        valid_o,
  output logic [31:0] current_batch_o,
  output logic [31:0] completed_batch_o,
  output logic        released_o,
  output logic        grace_ended_o,
  output logic        started_o,
  // configuration write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  import gpd_pkg::*;

  localparam int CpuW = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;

  // ---------------------------------------------------------------------------
  // Configuration masks. The user must write them only while the block is idle;
  // the block does not enforce this itself, and always takes the beat.
  // ---------------------------------------------------------------------------
  logic [15:0] online_q;
  logic [15:0] nohz_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      online_q <= ONLINE_RESET;
      nohz_q   <= NOHZ_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_ONLINE: online_q <= cfg_data_i;
        REG_NOHZ:   nohz_q   <= cfg_data_i;
        default:    online_q <= online_q;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Accept stage: latch the event and launch the memory read.
  // ---------------------------------------------------------------------------
  logic            accept;
  logic            cpu_ok;
  logic [CpuW-1:0] cpu_idx;

  logic            ex_q;
  logic [1:0]      ex_cmd_q;
  logic [CpuW-1:0] ex_idx_q;
  logic            ex_has_new_q;
  logic            ex_ok_q;

  assign busy_o  = ex_q;
  assign accept  = start_i && !busy_o;
  assign cpu_ok  = (32'(cpu_i) < NUM_CPUS);
  assign cpu_idx = CpuW'(cpu_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ex_q <= 1'b0;
    end else begin
      ex_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      ex_cmd_q     <= cmd_i;
      ex_idx_q     <= cpu_idx;
      ex_has_new_q <= has_new_i;
      ex_ok_q      <= cpu_ok;
    end
  end

  // ---------------------------------------------------------------------------
  // Per-processor tracking memory. One read port at accept, one write port at
  // the end of the execute cycle. Since the next event is taken no earlier than
  // the edge after the write, a read never overlaps a pending write.
  // An entry that was never written reads as all zero through its valid bit.
  // ---------------------------------------------------------------------------
  cpu_entry_t          mem_q [NUM_CPUS];
  cpu_entry_t          rd_q;
  logic                rd_vld_q;
  logic [NUM_CPUS-1:0] vld_q;
  logic                wr_en;
  cpu_entry_t          wr_data;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rd_q <= mem_q[cpu_idx];
    end
    if (wr_en) begin
      mem_q[ex_idx_q] <= wr_data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (accept) begin
        rd_vld_q <= cpu_ok && vld_q[cpu_idx];
      end
      if (wr_en) begin
        vld_q[ex_idx_q] <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Global grace period state.
  // ---------------------------------------------------------------------------
  logic [31:0]         cur_q, cur_d;
  logic [31:0]         done_q, done_d;
  logic                start_req_q, start_req_d;
  logic [NUM_CPUS-1:0] wait_q, wait_d;

  // Processors that a new batch waits for: online and not tickless idle
  logic [NUM_CPUS-1:0] start_mask;
  logic [NUM_CPUS-1:0] cpu_bit;

  assign start_mask = NUM_CPUS'(online_q & ~nohz_q);
  assign cpu_bit    = NUM_CPUS'(1) << ex_idx_q;

  // Wrap-safe order: a is before b when a - b is negative
  function automatic logic is_before(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] diff;
    diff = a - b;
    return diff[31];
  endfunction

  // ---------------------------------------------------------------------------
  // Execute: modify the entry read last cycle and update the global state.
  // ---------------------------------------------------------------------------
  cpu_entry_t ent;
  logic       quiet;
  logic       rel;
  logic       ended;
  logic       started;

  always_comb begin
    ent         = rd_vld_q ? rd_q : '0;
    wr_data     = ent;
    wr_en       = 1'b0;
    cur_d       = cur_q;
    done_d      = done_q;
    start_req_d = start_req_q;
    wait_d      = wait_q;
    quiet       = 1'b0;
    rel         = 1'b0;
    ended       = 1'b0;
    started     = 1'b0;

    if (ex_q && ex_ok_q) begin
      case (ex_cmd_q)
        CMD_TICK: begin
          wr_en              = 1'b1;
          wr_data.qs_counter = ent.qs_counter + 32'd1;
        end
        CMD_PROCESS: begin
          wr_en = 1'b1;
          // release held work once its batch has completed
          if (ent.holds_current && !is_before(done_q, ent.wait_batch)) begin
            wr_data.holds_current = 1'b0;
            rel                   = 1'b1;
          end
          // adopt new work into the next batch and ask for a start
          if (ex_has_new_q && !wr_data.holds_current) begin
            wr_data.holds_current = 1'b1;
            wr_data.wait_batch    = cur_q + 32'd1;
            if (!start_req_q) begin
              if (done_q == cur_q) begin
                wait_d  = start_mask;
                cur_d   = cur_q + 32'd1;
                started = 1'b1;
              end else begin
                start_req_d = 1'b1;
              end
            end
          end
          // notice a new batch, or report a quiescent state for this one
          if (ent.seen_batch != cur_d) begin
            wr_data.qs_wanted   = 1'b1;
            wr_data.qs_snapshot = ent.qs_counter;
            wr_data.seen_batch  = cur_d;
          end else if (ent.qs_wanted && (ent.qs_counter != ent.qs_snapshot)) begin
            wr_data.qs_wanted = 1'b0;
            quiet             = 1'b1;
          end
        end
        CMD_ONLINE: begin
          wr_en              = 1'b1;
          wr_data            = '0;
          wr_data.seen_batch = done_q;
        end
        CMD_OFFLINE: begin
          quiet = (cur_q != done_q);
        end
        default: begin
          quiet = 1'b0;
        end
      endcase
    end

    // Drop this processor from the batch; the last one completes it and
    // starts the next batch if one is pending.
    if (quiet) begin
      wait_d = wait_d & ~cpu_bit;
      if (wait_d == '0) begin
        done_d = cur_d;
        ended  = 1'b1;
        if (start_req_d) begin
          wait_d      = start_mask;
          start_req_d = 1'b0;
          cur_d       = cur_d + 32'd1;
          started     = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q       <= RESET_NUMBER;
      done_q      <= RESET_NUMBER;
      start_req_q <= 1'b0;
      wait_q      <= '0;
    end else begin
      cur_q       <= cur_d;
      done_q      <= done_d;
      start_req_q <= start_req_d;
      wait_q      <= wait_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Result beat: one cycle strobe; the numbers are the live counters.
  // ---------------------------------------------------------------------------
  logic valid_q;
  logic rel_q;
  logic ended_q;
  logic started_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q   <= 1'b0;
      rel_q     <= 1'b0;
      ended_q   <= 1'b0;
      started_q <= 1'b0;
    end else begin
      valid_q   <= ex_q;
      rel_q     <= rel;
      ended_q   <= ended;
      started_q <= started;
    end
  end

  assign valid_o           = valid_q;
  assign current_batch_o   = cur_q;
  assign completed_batch_o = done_q;
  assign released_o        = rel_q;
  assign grace_ended_o     = ended_q;
  assign started_o         = started_q;

`ifndef SYNTHESIS
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ex_q |=> !ex_q)
    else $error("execute stage held two events back to back");

  a_flags_with_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (started_o || grace_ended_o || released_o) |-> valid_o)
    else $error("result flag raised outside a result beat");

  a_beat_follows_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(ex_q))
    else $error("result beat without an executed event");

  a_pending_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_req_q |-> (cur_q != done_q))
    else $error("start request pending while no batch is in progress");

  a_end_numbers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    grace_ended_o |-> ((current_batch_o == completed_batch_o) ||
                       (started_o && (current_batch_o == completed_batch_o + 32'd1))))
    else $error("completed batch does not match current batch at grace end");
`endif

endmodule
